>>> rtl/nce_pkg.sv
`timescale 1ns / 1ps

package nce_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_ORDER  = 8;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int WIN_AW     = $clog2(MAX_ORDER);
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);

    localparam int BASIS_W = 31;
    localparam logic [BASIS_W-1:0] BASIS_ONE = 31'h4000_0000;

    localparam int DIV_NW = 60;
    localparam int DIV_DW = 27;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SPLINE_ORDER = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [23:0] w;
    } point_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SETUP,
        S_LIN_RD0,
        S_LIN_RD1,
        S_LIN_CAP,
        S_LIN_MUL,
        S_LIN_DIV,
        S_LIN_WAIT,
        S_TQ_START,
        S_TQ_WAIT,
        S_SPAN,
        S_BAS_T,
        S_BAS_ABS,
        S_BAS_DIV,
        S_BAS_WR,
        S_SUM_RD,
        S_SUM_BW,
        S_SUM_MUL,
        S_SUM_ADD,
        S_FIN,
        S_FIN_DIV,
        S_FIN_WAIT,
        S_DONE
    } state_t;

endpackage

>>> rtl/nce_if.sv
`timescale 1ns / 1ps

interface nce_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [5:0]         point_index;
    logic signed [31:0] ctrl_x;
    logic signed [31:0] ctrl_y;
    logic signed [31:0] ctrl_z;
    logic [23:0]        ctrl_weight;
    logic [15:0]        sample_index;

    modport source (output valid, req_type, point_index, ctrl_x, ctrl_y, ctrl_z,
                    ctrl_weight, sample_index, input ready);
    modport sink (input valid, req_type, point_index, ctrl_x, ctrl_y, ctrl_z,
                  ctrl_weight, sample_index, output ready);
endinterface

interface nce_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               zero_weight_sum;

    modport source (output valid, pos_x, pos_y, pos_z, zero_weight_sum, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, zero_weight_sum, output ready);
endinterface

>>> rtl/nce_point_mem.sv
`timescale 1ns / 1ps

module nce_point_mem
    import nce_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PT_AW-1:0] wr_addr,
    input  point_t           wr_data,
    input  logic             rd_en,
    input  logic [PT_AW-1:0] rd_addr,
    output point_t           rd_data
);

    point_t mem [MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/nce_div.sv
`timescale 1ns / 1ps

module nce_div
    import nce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/nurbs_curve_evaluator_unit.sv
`timescale 1ns / 1ps

// Rational B-spline curve sampler. A write word stores one weighted control point in a
// point memory with separate read and write ports. An evaluate word runs one at a time:
// a two-point curve uses three serial divisions, one per axis. Other curves run the
// parameter division, then order-1 passes of eight basis slots, each slot's terms going
// through a small serial divider, then one read on the point memory port per active
// point, then one final division per axis (skipped when the weight sum is zero). A
// finished result waits in an output register while the next word is accepted.
module nurbs_curve_evaluator_unit
    import nce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_wr_data,
    nce_req_if.sink          req,
    nce_res_if.source        res
);

    function automatic logic [5:0] knot_at(logic [7:0] j, logic [WIN_AW-1:0] d,
                                           logic [5:0] len);
        logic [7:0] rel;
        rel = j - 8'(d);
        if (j <= 8'(d))
        begin
            return 6'd0;
        end
        else if (rel >= 8'(len))
        begin
            return len;
        end
        return rel[5:0];
    endfunction

    function automatic coord_t sat32(logic signed [61:0] v);
        if (v > 62'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < -62'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic coord_t coord_of(point_t p, logic [1:0] c);
        unique case (c)
            2'd0:    return p.x;
            2'd1:    return p.y;
            default: return p.z;
        endcase
    endfunction

    state_t state_reg, state_next;

    logic [6:0]  pc_reg;
    logic [3:0]  so_reg;
    logic [15:0] sc_reg;

    logic [ORD_W-1:0]    ord_reg;
    logic [WIN_AW-1:0]   d_reg;
    logic [PT_AW-1:0]    n_reg;
    logic [5:0]          len_reg;
    logic [15:0]         sm1_reg;
    logic [15:0]         idx_reg;
    logic [21:0]         tq_reg;
    logic [PT_AW-1:0]    base_reg;
    logic [BASIS_W-1:0]  w_reg [MAX_ORDER];
    logic [ORD_W-1:0]    k_reg;
    logic [WIN_AW-1:0]   j_reg;
    logic                term_reg;
    logic signed [54:0]  prod_reg;
    logic [2:0]          den_reg;
    logic [35:0]         sd_a_reg;
    logic [35:0]         sd_q_reg;
    logic [2:0]          sd_r_reg;
    logic [2:0]          sd_cnt_reg;
    logic                neg_reg;
    logic signed [37:0]  acc_reg;
    logic [23:0]         bw_reg;
    logic signed [56:0]  pm_reg [3];
    logic [26:0]         sw_reg;
    logic signed [59:0]  ac_reg [3];
    logic [1:0]          c_reg;
    point_t              p0_reg;
    point_t              p1_reg;
    logic signed [49:0]  lprod_reg;
    coord_t              rx_reg [3];
    logic                rz_reg;
    logic                out_valid_reg;
    coord_t              ox_reg;
    coord_t              oy_reg;
    coord_t              oz_reg;
    logic                oz_flag_reg;

    logic                mem_we;
    logic                mem_re;
    logic [PT_AW-1:0]    mem_raddr;
    point_t              mem_wdata;
    point_t              mem_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [6:0]          np_c;
    logic [3:0]          ord_c;
    logic [15:0]         sm1_c;
    logic [7:0]          i_pos;
    logic [5:0]          knot_a;
    logic [5:0]          knot_b;
    logic [5:0]          den_c;
    logic signed [22:0]  num_c;
    logic [BASIS_W-1:0]  b_op;
    logic                skip_entry;
    logic                skip_term;
    logic [35:0]         sd_a_c;
    logic [35:0]         sd_q_c;
    logic [2:0]          sd_r_c;
    logic [3:0]          sd_t;
    logic signed [37:0]  term_val;
    logic [BASIS_W-1:0]  clamped;
    logic [54:0]         prod_mag;
    logic [54:0]         bw_full;
    logic [59:0]         ac_mag;
    logic [49:0]         lprod_mag;
    logic signed [61:0]  q_signed;
    logic signed [32:0]  diff_c;
    logic                accept;
    logic                res_load;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign mem_we    = accept && (req.req_type == REQ_WRITE);
    assign mem_wdata = '{x: req.ctrl_x, y: req.ctrl_y, z: req.ctrl_z, w: req.ctrl_weight};

    nce_point_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (req.point_index),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    nce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        np_c = pc_reg;
        if (pc_reg < 7'd2)
        begin
            np_c = 7'd2;
        end
        else if (pc_reg > 7'(MAX_POINTS))
        begin
            np_c = 7'(MAX_POINTS);
        end
        ord_c = (so_reg > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : so_reg;
        if (7'(ord_c) > np_c)
        begin
            ord_c = np_c[3:0];
        end
        if (ord_c < 4'd2)
        begin
            ord_c = 4'd2;
        end
        sm1_c = (sc_reg >= 16'd2) ? sc_reg - 16'd1 : 16'd1;
    end

    always_comb
    begin
        i_pos = 8'(base_reg) + 8'(j_reg);
        if (!term_reg)
        begin
            knot_a = knot_at(i_pos, d_reg, len_reg);
            knot_b = knot_at(i_pos + 8'(k_reg) - 8'd1, d_reg, len_reg);
            num_c  = $signed({1'b0, tq_reg}) - $signed({1'b0, knot_a, 16'b0});
            b_op   = w_reg[0];
        end
        else
        begin
            knot_a = knot_at(i_pos + 8'd1, d_reg, len_reg);
            knot_b = knot_at(i_pos + 8'(k_reg), d_reg, len_reg);
            num_c  = $signed({1'b0, knot_b, 16'b0}) - $signed({1'b0, tq_reg});
            b_op   = (j_reg == WIN_AW'(MAX_ORDER - 1)) ? '0 : w_reg[1];
        end
        den_c      = knot_b - knot_a;
        skip_entry = j_reg > d_reg;
        skip_term  = (den_c == 6'd0) || (b_op == '0);
    end

    always_comb
    begin
        sd_a_c = sd_a_reg;
        sd_q_c = sd_q_reg;
        sd_r_c = sd_r_reg;
        sd_t   = '0;
        for (int s = 0; s < 6; s++)
        begin
            sd_t   = {sd_r_c, sd_a_c[35]};
            sd_a_c = {sd_a_c[34:0], 1'b0};
            if (sd_t >= {1'b0, den_reg})
            begin
                sd_t   = sd_t - {1'b0, den_reg};
                sd_q_c = {sd_q_c[34:0], 1'b1};
            end
            else
            begin
                sd_q_c = {sd_q_c[34:0], 1'b0};
            end
            sd_r_c = sd_t[2:0];
        end
        term_val = neg_reg ? -$signed({2'b0, sd_q_c}) : $signed({2'b0, sd_q_c});
    end

    always_comb
    begin
        if (acc_reg < 0)
        begin
            clamped = '0;
        end
        else if (acc_reg > $signed({7'b0, BASIS_ONE}))
        begin
            clamped = BASIS_ONE;
        end
        else
        begin
            clamped = acc_reg[BASIS_W-1:0];
        end
        prod_mag  = prod_reg[54] ? 55'(-prod_reg) : 55'(prod_reg);
        bw_full   = 55'(w_reg[0]) * 55'(mem_rdata.w);
        ac_mag    = ac_reg[c_reg][59] ? 60'(-ac_reg[c_reg]) : 60'(ac_reg[c_reg]);
        lprod_mag = lprod_reg[49] ? 50'(-lprod_reg) : 50'(lprod_reg);
        q_signed  = neg_reg ? -$signed({2'b0, div_rsp.quotient})
                            : $signed({2'b0, div_rsp.quotient});
        diff_c    = 33'(coord_of(p1_reg, c_reg)) - 33'(coord_of(p0_reg, c_reg));
    end

    assign res_load = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next       = state_reg;
        mem_re           = 1'b0;
        mem_raddr        = base_reg + PT_AW'(j_reg);
        div_req.start    = 1'b0;
        div_req.dividend = 60'({idx_reg * 22'(len_reg), 16'b0});
        div_req.divisor  = 27'(sm1_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.req_type == REQ_EVAL))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = (np_c == 7'd2) ? S_LIN_RD0 : S_TQ_START;
            end
            S_LIN_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_LIN_RD1;
            end
            S_LIN_RD1:
            begin
                mem_re     = 1'b1;
                mem_raddr  = PT_AW'(1);
                state_next = S_LIN_CAP;
            end
            S_LIN_CAP:
            begin
                state_next = S_LIN_MUL;
            end
            S_LIN_MUL:
            begin
                state_next = S_LIN_DIV;
            end
            S_LIN_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 60'(lprod_mag) + 60'(sm1_reg >> 1);
                state_next       = S_LIN_WAIT;
            end
            S_LIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (c_reg == 2'd2) ? S_DONE : S_LIN_MUL;
                end
            end
            S_TQ_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_TQ_WAIT;
            end
            S_TQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                state_next = S_BAS_T;
            end
            S_BAS_T:
            begin
                if (skip_entry || (skip_term && term_reg))
                begin
                    state_next = S_BAS_WR;
                end
                else if (!skip_term)
                begin
                    state_next = S_BAS_ABS;
                end
            end
            S_BAS_ABS:
            begin
                state_next = S_BAS_DIV;
            end
            S_BAS_DIV:
            begin
                if (sd_cnt_reg == 3'd5)
                begin
                    state_next = term_reg ? S_BAS_WR : S_BAS_T;
                end
            end
            S_BAS_WR:
            begin
                if (j_reg == WIN_AW'(MAX_ORDER - 1) && k_reg == ord_reg)
                begin
                    state_next = S_SUM_RD;
                end
                else
                begin
                    state_next = S_BAS_T;
                end
            end
            S_SUM_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SUM_BW;
            end
            S_SUM_BW:
            begin
                state_next = S_SUM_MUL;
            end
            S_SUM_MUL:
            begin
                state_next = S_SUM_ADD;
            end
            S_SUM_ADD:
            begin
                state_next = (j_reg == d_reg) ? S_FIN : S_SUM_RD;
            end
            S_FIN:
            begin
                state_next = (sw_reg == '0) ? S_DONE : S_FIN_DIV;
            end
            S_FIN_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ac_mag + 60'(sw_reg >> 1);
                div_req.divisor  = sw_reg;
                state_next       = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (c_reg == 2'd2) ? S_DONE : S_FIN_DIV;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 7'd4;
            so_reg        <= 4'd4;
            sc_reg        <= 16'd100;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_POINT_COUNT:  pc_reg <= cfg_wr_data[6:0];
                    CFG_SPLINE_ORDER: so_reg <= cfg_wr_data[3:0];
                    CFG_SAMPLE_COUNT: sc_reg <= cfg_wr_data;
                    default:          ;
                endcase
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ox_reg      <= rx_reg[0];
            oy_reg      <= rx_reg[1];
            oz_reg      <= rx_reg[2];
            oz_flag_reg <= rz_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_reg <= req.sample_index;
                end
            end
            S_SETUP:
            begin
                ord_reg <= ord_c;
                d_reg   <= WIN_AW'(ord_c - 4'd1);
                n_reg   <= PT_AW'(np_c - 7'd1);
                len_reg <= 6'(np_c - 7'(ord_c) + 7'd1);
                sm1_reg <= sm1_c;
                idx_reg <= (idx_reg > sm1_c) ? sm1_c : idx_reg;
                c_reg   <= '0;
                rz_reg  <= 1'b0;
            end
            S_LIN_CAP:
            begin
                p0_reg <= p1_reg;
                p1_reg <= mem_rdata;
            end
            S_LIN_RD1:
            begin
                p1_reg <= mem_rdata;
            end
            S_LIN_MUL:
            begin
                lprod_reg <= $signed({1'b0, idx_reg}) * diff_c;
            end
            S_LIN_DIV:
            begin
                neg_reg <= lprod_reg[49];
            end
            S_LIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rx_reg[c_reg] <= sat32(62'(coord_of(p0_reg, c_reg)) + q_signed);
                    c_reg         <= c_reg + 2'd1;
                end
            end
            S_TQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    tq_reg <= div_rsp.quotient[21:0];
                end
            end
            S_SPAN:
            begin
                if (tq_reg >= {len_reg, 16'b0})
                begin
                    base_reg <= n_reg - PT_AW'(d_reg);
                end
                else
                begin
                    base_reg <= PT_AW'(tq_reg[21:16]);
                end
                for (int m = 0; m < MAX_ORDER; m++)
                begin
                    w_reg[m] <= (WIN_AW'(m) == d_reg) ? BASIS_ONE : '0;
                end
                k_reg    <= ORD_W'(2);
                j_reg    <= '0;
                term_reg <= 1'b0;
                acc_reg  <= '0;
                sw_reg   <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    ac_reg[c] <= '0;
                end
            end
            S_BAS_T:
            begin
                if (!skip_entry)
                begin
                    if (!skip_term)
                    begin
                        prod_reg <= num_c * $signed({1'b0, b_op});
                        den_reg  <= den_c[2:0];
                    end
                    else if (!term_reg)
                    begin
                        term_reg <= 1'b1;
                    end
                end
            end
            S_BAS_ABS:
            begin
                sd_a_reg   <= prod_mag[51:16];
                sd_q_reg   <= '0;
                sd_r_reg   <= '0;
                sd_cnt_reg <= '0;
                neg_reg    <= prod_reg[54];
            end
            S_BAS_DIV:
            begin
                sd_a_reg   <= sd_a_c;
                sd_q_reg   <= sd_q_c;
                sd_r_reg   <= sd_r_c;
                sd_cnt_reg <= sd_cnt_reg + 3'd1;
                if (sd_cnt_reg == 3'd5)
                begin
                    acc_reg  <= acc_reg + term_val;
                    term_reg <= 1'b1;
                end
            end
            S_BAS_WR:
            begin
                for (int m = 0; m < MAX_ORDER - 1; m++)
                begin
                    w_reg[m] <= w_reg[m + 1];
                end
                w_reg[MAX_ORDER - 1] <= clamped;
                acc_reg  <= '0;
                term_reg <= 1'b0;
                j_reg    <= j_reg + WIN_AW'(1);
                if (j_reg == WIN_AW'(MAX_ORDER - 1))
                begin
                    j_reg <= '0;
                    k_reg <= k_reg + ORD_W'(1);
                end
            end
            S_SUM_BW:
            begin
                bw_reg <= bw_full[53:30];
                for (int m = 0; m < MAX_ORDER - 1; m++)
                begin
                    w_reg[m] <= w_reg[m + 1];
                end
                w_reg[MAX_ORDER - 1] <= '0;
            end
            S_SUM_MUL:
            begin
                pm_reg[0] <= $signed({1'b0, bw_reg}) * mem_rdata.x;
                pm_reg[1] <= $signed({1'b0, bw_reg}) * mem_rdata.y;
                pm_reg[2] <= $signed({1'b0, bw_reg}) * mem_rdata.z;
            end
            S_SUM_ADD:
            begin
                sw_reg <= sw_reg + 27'(bw_reg);
                for (int c = 0; c < 3; c++)
                begin
                    ac_reg[c] <= ac_reg[c] + 60'(pm_reg[c]);
                end
                j_reg <= j_reg + WIN_AW'(1);
            end
            S_FIN:
            begin
                c_reg <= '0;
                if (sw_reg == '0)
                begin
                    rz_reg <= 1'b1;
                    for (int c = 0; c < 3; c++)
                    begin
                        rx_reg[c] <= '0;
                    end
                end
            end
            S_FIN_DIV:
            begin
                neg_reg <= ac_reg[c_reg][59];
            end
            S_FIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rx_reg[c_reg] <= sat32(q_signed);
                    c_reg         <= c_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid           = out_valid_reg;
    assign res.pos_x           = ox_reg;
    assign res.pos_y           = oy_reg;
    assign res.pos_z           = oz_reg;
    assign res.zero_weight_sum = oz_flag_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_weight_sum |->
            res.pos_x == 0 && res.pos_y == 0 && res.pos_z == 0)
        else $error("zero weight sum result carries a nonzero coordinate");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM_BW |-> w_reg[0] <= BASIS_ONE)
        else $error("basis value above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_EVAL |=> state_reg == S_SETUP)
        else $error("evaluate word not started");
`endif

endmodule

>>> tb/nurbs_curve_evaluator_unit_test.sv
`timescale 1ns / 1ps

module nurbs_curve_evaluator_unit_test;
    import nce_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   zws;
    } curve_point_t;

    typedef struct {
        logic        kind;
        logic [5:0]  slot;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [23:0] w;
        logic [15:0] sidx;
        logic        typed;
        logic        zws;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wr_data;

    nce_req_if req ();
    nce_res_if res ();

    nurbs_curve_evaluator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .req         (req.sink),
        .res         (res.source)
    );

    coord_t      store_x [MAX_POINTS];
    coord_t      store_y [MAX_POINTS];
    coord_t      store_z [MAX_POINTS];
    logic [23:0] store_w [MAX_POINTS];
    logic [6:0]  reg_points;
    logic [3:0]  reg_order;
    logic [15:0] reg_samples;

    curve_point_t expected_points [$];
    int           error_count;
    int           idle_cycles;
    int           send_idle_pct;
    int           stall_pct;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint knot(longint j, longint d, longint spans);
        if (j <= d)
            return 0;
        if (j - d >= spans)
            return spans;
        return j - d;
    endfunction

    function automatic longint round_div(longint a, longint b);
        if (a >= 0)
            return (a + b / 2) / b;
        return -((-a + b / 2) / b);
    endfunction

    function automatic coord_t saturate(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return coord_t'(v);
    endfunction

    function automatic curve_point_t evaluate_curve(logic [15:0] sidx);
        longint np, ord, sm1, id, n, d, spans, tq, ki, ki1, kik1, kik, acc, bw;
        longint sw, ax, ay, az, x0, y0, z0;
        longint basis [MAX_POINTS + 1];
        curve_point_t r;
        np = reg_points;
        if (np < 2)
            np = 2;
        if (np > MAX_POINTS)
            np = MAX_POINTS;
        ord = reg_order;
        if (ord > MAX_ORDER)
            ord = MAX_ORDER;
        if (ord > np)
            ord = np;
        if (ord < 2)
            ord = 2;
        sm1 = (reg_samples >= 2) ? longint'(reg_samples) - 1 : 1;
        id = sidx;
        if (id > sm1)
            id = sm1;
        r.zws = 1'b0;
        if (np == 2)
        begin
            x0 = store_x[0];
            y0 = store_y[0];
            z0 = store_z[0];
            r.x = saturate(x0 + round_div(id * (longint'(store_x[1]) - x0), sm1));
            r.y = saturate(y0 + round_div(id * (longint'(store_y[1]) - y0), sm1));
            r.z = saturate(z0 + round_div(id * (longint'(store_z[1]) - z0), sm1));
            return r;
        end
        n = np - 1;
        d = ord - 1;
        spans = np - ord + 1;
        tq = (id * spans * 65536) / sm1;
        foreach (basis[i])
            basis[i] = 0;
        if (tq >= spans * 65536)
            basis[n] = 64'sd1 << 30;
        else
            basis[d + (tq >>> 16)] = 64'sd1 << 30;
        for (longint k = 2; k <= ord; k++)
        begin
            for (longint i = 0; i <= n; i++)
            begin
                ki = knot(i, d, spans);
                ki1 = knot(i + 1, d, spans);
                kik1 = knot(i + k - 1, d, spans);
                kik = knot(i + k, d, spans);
                acc = 0;
                if (kik1 != ki)
                    acc += ((tq - ki * 65536) * basis[i]) / ((kik1 - ki) * 65536);
                if (kik != ki1)
                    acc += ((kik * 65536 - tq) * basis[i + 1]) / ((kik - ki1) * 65536);
                if (acc < 0)
                    acc = 0;
                if (acc > (64'sd1 << 30))
                    acc = 64'sd1 << 30;
                basis[i] = acc;
            end
        end
        sw = 0;
        ax = 0;
        ay = 0;
        az = 0;
        for (int i = 0; i <= n; i++)
        begin
            bw = (basis[i] * longint'(store_w[i])) >>> 30;
            sw += bw;
            ax += bw * longint'(store_x[i]);
            ay += bw * longint'(store_y[i]);
            az += bw * longint'(store_z[i]);
        end
        if (sw == 0)
        begin
            r.x = 0;
            r.y = 0;
            r.z = 0;
            r.zws = 1'b1;
            return r;
        end
        r.x = saturate(round_div(ax, sw));
        r.y = saturate(round_div(ay, sw));
        r.z = saturate(round_div(az, sw));
        return r;
    endfunction

    task automatic send_word(stim_row_t s);
        int gap;
        curve_point_t p;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            if (req.valid)
                req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= s.kind;
        req.point_index  <= s.slot;
        req.ctrl_x       <= s.x;
        req.ctrl_y       <= s.y;
        req.ctrl_z       <= s.z;
        req.ctrl_weight  <= s.w;
        req.sample_index <= s.sidx;
        do
            @(posedge clk);
        while (!req.ready);
        if (s.kind == REQ_WRITE)
        begin
            store_x[s.slot] = s.x;
            store_y[s.slot] = s.y;
            store_z[s.slot] = s.z;
            store_w[s.slot] = s.w;
        end
        else if (s.typed)
        begin
            p.x = 0;
            p.y = 0;
            p.z = 0;
            p.zws = s.zws;
            expected_points.push_back(p);
        end
        else
            expected_points.push_back(evaluate_curve(s.sidx));
    endtask

    task automatic set_register(logic [1:0] index, logic [15:0] value);
        if (req.valid)
            req.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_POINT_COUNT)
            reg_points = value[6:0];
        else if (index == CFG_SPLINE_ORDER)
            reg_order = value[3:0];
        else if (index == CFG_SAMPLE_COUNT)
            reg_samples = value;
    endtask

    function automatic stim_row_t random_write(logic [5:0] slot);
        stim_row_t s;
        s.kind = REQ_WRITE;
        s.slot = slot;
        s.x = $urandom_range(3) == 0 ? $urandom_range(2000) - 1000 : $urandom;
        s.y = $urandom;
        s.z = $urandom_range(3) == 0 ? 32'sh80000000 : $urandom;
        case ($urandom_range(9))
            0: s.w = 0;
            1: s.w = 24'hffffff;
            2: s.w = 24'h010000;
            default: s.w = 24'($urandom);
        endcase
        s.sidx = 16'($urandom);
        s.typed = 1'b0;
        s.zws = 1'b0;
        return s;
    endfunction

    function automatic stim_row_t random_eval();
        stim_row_t s;
        s = random_write(6'($urandom));
        s.kind = REQ_EVAL;
        case ($urandom_range(9))
            0: s.sidx = 0;
            1: s.sidx = 16'hffff;
            2: s.sidx = (reg_samples > 0) ? reg_samples - 16'd1 : 16'd0;
            3, 4, 5: s.sidx = 16'($urandom_range(reg_samples > 0 ? reg_samples - 1 : 0));
            default: s.sidx = 16'($urandom);
        endcase
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        curve_point_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result word x=%h", res.pos_x);
                error_count++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (res.pos_x !== e.x)
                begin
                    $error("pos_x expected %h actual %h", e.x, res.pos_x);
                    error_count++;
                end
                if (res.pos_y !== e.y)
                begin
                    $error("pos_y expected %h actual %h", e.y, res.pos_y);
                    error_count++;
                end
                if (res.pos_z !== e.z)
                begin
                    $error("pos_z expected %h actual %h", e.z, res.pos_z);
                    error_count++;
                end
                if (res.zero_weight_sum !== e.zws)
                begin
                    $error("zero_weight_sum expected %b actual %b", e.zws,
                           res.zero_weight_sum);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t s;
        int phase_points [9];
        int phase_order [9];
        int phase_samples [9];
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POINT_COUNT;
        cfg_wr_data = 0;
        req.valid = 1'b0;
        req.req_type = REQ_WRITE;
        req.point_index = 0;
        req.ctrl_x = 0;
        req.ctrl_y = 0;
        req.ctrl_z = 0;
        req.ctrl_weight = 0;
        req.sample_index = 0;
        reg_points = 4;
        reg_order = 4;
        reg_samples = 100;
        foreach (store_x[i])
        begin
            store_x[i] = 0;
            store_y[i] = 0;
            store_z[i] = 0;
            store_w[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme points under the reset settings, then an all-zero weight set.
        table_rows = '{
            '{REQ_WRITE, 0, 32'sh7fffffff, 32'sh80000000, 0, 24'hffffff, 0, 0, 0},
            '{REQ_WRITE, 1, 32'sh80000000, 32'sh7fffffff, -1, 24'h000001, 0, 0, 0},
            '{REQ_WRITE, 2, 32'sh00010000, -32'sh00010000, 32'sh7fffffff, 0, 0, 0, 0},
            '{REQ_WRITE, 3, -5, 7, 32'sh80000000, 24'h010000, 0, 0, 0},
            '{REQ_WRITE, 63, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff,
              0, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 99, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 16'hffff, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 50, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 1, 0, 0},
            '{REQ_WRITE, 0, 100, 200, 300, 0, 0, 0, 0},
            '{REQ_WRITE, 1, -100, 0, 1, 0, 0, 0, 0},
            '{REQ_WRITE, 2, 5, 5, 5, 0, 0, 0, 0},
            '{REQ_WRITE, 3, 9, 9, 9, 0, 0, 0, 0},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 0, 1, 1},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 42, 1, 1},
            '{REQ_EVAL, 0, 0, 0, 0, 0, 99, 1, 1}
        };
        foreach (table_rows[i])
            send_word(table_rows[i]);

        phase_points  = '{2, 64, 64, 0, 127, 10, 5, 3, 2};
        phase_order   = '{2, 8, 2, 0, 15, 3, 8, 3, 15};
        phase_samples = '{2, 65535, 3, 0, 1, 1000, 50, 7, 65535};
        for (int ph = 0; ph < 9; ph++)
        begin
            set_register(CFG_POINT_COUNT, 16'(phase_points[ph]));
            set_register(CFG_SPLINE_ORDER, 16'(phase_order[ph]));
            set_register(CFG_SAMPLE_COUNT, 16'(phase_samples[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            for (int i = 0; i < MAX_POINTS; i++)
                send_word(random_write(6'(i)));
            for (int i = 0; i < 60; i++)
            begin
                if ($urandom_range(9) < 7)
                    s = random_eval();
                else
                    s = random_write(6'($urandom));
                send_word(s);
            end
        end

        req.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
